// ===== hw/rtl/synthetic_seismogram_convolver_assert.svh =====
// Assertion macros used by the synthetic seismogram convolver top level.
// Needs nothing else; files that check their own logic include it.
`ifndef SYNTHETIC_SEISMOGRAM_CONVOLVER_ASSERT_SVH
`define SYNTHETIC_SEISMOGRAM_CONVOLVER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SSC_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define SSC_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/ssc_pkg.sv =====
// Shared types and constants of the synthetic seismogram convolver.
// No dependencies; used by ssc_ctrl, ssc_datapath and the top level.
package ssc_pkg;

   // Field widths of the request and response words
   localparam int IDX_IN_W   = 5;
   localparam int TAP_W      = 16;
   localparam int VEL_W      = 14;
   localparam int DEN_W      = 12;
   localparam int IMP_W      = 26;
   localparam int SYNTH_W    = 24;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 24;

   // Bit positions inside req_tdata
   localparam int TIDX_LSB = 0;
   localparam int TVAL_LSB = 5;
   localparam int VEL_LSB  = 21;
   localparam int DEN_LSB  = 35;

   // Reflection quotient: 16 restoring steps
   localparam int DIV_STEPS = 16;
   localparam int DIV_CNT_W = 4;

   // Kind of request word (req_tuser)
   typedef enum logic {
      CMD_LOAD   = 1'b0,
      CMD_SAMPLE = 1'b1
   } req_kind_type;

   // Controller to datapath
   typedef struct packed {
      logic load_tap;
      logic take_sample;
      logic setup;
      logic div_step;
      logic shift_refl;
      logic shift_zero;
      logic mac_clear;
      logic mac_run;
      logic push;
      logic push_final;
      logic clear_trace;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_sample;
      logic have_prev;
      logic last;
      logic mac_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== hw/rtl/synthetic_seismogram_convolver.sv =====
// A log sample with a predecessor goes through setup, the 16-step divider, a
// line shift, the single MAC, a drain and a push; a first sample skips the
// divider and shift. Each tail flush word of a last sample takes a zero shift,
// a MAC pass and a push. One log sample is worked on at a time, and a push
// waits while the response register holds a word not yet taken; a tap load is
// taken in idle. Synchronous reset clears taps, delay line and previous impedance.
`include "synthetic_seismogram_convolver_assert.svh"

module synthetic_seismogram_convolver import ssc_pkg::*; #(
   parameter int TAPS = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // tap_index[4:0], tap_value[20:5], velocity[34:21], density_milli[46:35]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // synth_value[23:0]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   ssc_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (dp_status),
      .cmd        (dp_cmd)
   );

   ssc_datapath #(
      .TAPS (TAPS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .cmd        (dp_cmd),
      .status     (dp_status)
   );

   // Response register is never overwritten while a word still waits
   `SSC_ASSERT_SAME(a_push_free, clock, reset, dp_cmd.push, dp_status.out_free)

   // Final word only for a sample marked last
   `SSC_ASSERT_SAME(a_final_last, clock, reset, dp_cmd.push_final, dp_status.last)

   // Accepted log sample blocks the request side while it is worked on
   `SSC_ASSERT_NEXT(a_busy_after_sample, clock, reset, req_tvalid && req_tready && req_tuser == CMD_SAMPLE, !req_tready)

endmodule

// ===== hw/rtl/ssc_datapath.sv =====
// Datapath: tap store, impedance product, restoring divider, reflectivity
// line, multiply-accumulate and response register. Depends on ssc_pkg.
module ssc_datapath import ssc_pkg::*; #(
   parameter int TAPS = 25
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  dp_cmd_type            cmd,
   output dp_status_type         status
);

   localparam int IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int ACC_W = 2 * TAP_W + $clog2(TAPS) + 1;
   localparam int SHR_W = ACC_W - 15;
   localparam int EXT_W = 48;

   // Request fields
   logic        [IDX_IN_W-1:0] tap_index;
   logic signed [TAP_W-1:0]    tap_value;
   logic        [VEL_W-1:0]    velocity;
   logic        [DEN_W-1:0]    density_milli;

   assign tap_index     = req_tdata[TIDX_LSB +: IDX_IN_W];
   assign tap_value     = req_tdata[TVAL_LSB +: TAP_W];
   assign velocity      = req_tdata[VEL_LSB +: VEL_W];
   assign density_milli = req_tdata[DEN_LSB +: DEN_W];

   // State
   logic signed [TAP_W-1:0] taps_ff [TAPS];
   logic signed [TAP_W-1:0] line_ff [TAPS];
   logic [IMP_W-1:0]        z_ff;
   logic [IMP_W-1:0]        prev_ff;
   logic                    have_ff;
   logic                    last_ff;

   // Divider
   logic [IMP_W:0]     sum_ff;
   logic [IMP_W+1:0]   rem_ff;
   logic [15:0]        nlow_ff;
   logic [15:0]        q_ff;
   logic               neg_ff;
   logic               zero_ff;

   // MAC
   logic [IDX_W-1:0]         idx_ff;
   logic signed [2*TAP_W-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;

   // Response register
   logic                rsp_valid_ff;
   logic [SYNTH_W-1:0]  synth_ff;
   logic                rsp_last_ff;

   // Tap write is dropped when the index is past the end
   logic tap_in_range;
   assign tap_in_range = (6'(tap_index) < 6'(TAPS));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) taps_ff[k] <= '0;
      end else if (cmd.load_tap && tap_in_range) begin
         taps_ff[tap_index[IDX_W-1:0]] <= tap_value;
      end
   end

   // Impedance of the new sample and the last flag
   always_ff @(posedge clock) begin
      if (cmd.take_sample) begin
         z_ff    <= IMP_W'(velocity) * IMP_W'(density_milli);
         last_ff <= req_tlast;
      end
   end

   // Divider setup: sum, magnitude and the top of the scaled numerator
   logic [IMP_W:0]   sum_c;
   logic             neg_c;
   logic [IMP_W-1:0] mag_c;
   logic [41:0]      num_c;

   always_comb begin
      sum_c = {1'b0, z_ff} + {1'b0, prev_ff};
      neg_c = (z_ff < prev_ff);
      mag_c = neg_c ? (prev_ff - z_ff) : (z_ff - prev_ff);
      num_c = 42'({mag_c, 15'b0}) + 42'(sum_c[IMP_W:1]);
   end

   // One restoring step: bring in the next numerator bit
   logic [IMP_W+1:0] trial_c;
   logic             ge_c;
   assign trial_c = {rem_ff[IMP_W:0], nlow_ff[15]};
   assign ge_c    = (trial_c >= {1'b0, sum_ff});

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         sum_ff  <= sum_c;
         neg_ff  <= neg_c;
         zero_ff <= (sum_c == '0);
         rem_ff  <= (IMP_W+2)'(num_c[41:16]);
         nlow_ff <= num_c[15:0];
         q_ff    <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= ge_c ? (trial_c - {1'b0, sum_ff}) : trial_c;
         nlow_ff <= {nlow_ff[14:0], 1'b0};
         q_ff    <= {q_ff[14:0], ge_c};
      end
   end

   // Previous impedance; cleared at trace end
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_trace) begin
         prev_ff <= '0;
         have_ff <= 1'b0;
      end else if (cmd.setup) begin
         prev_ff <= z_ff;
         have_ff <= 1'b1;
      end
   end

   // Saturated Q1.15 reflection coefficient
   logic signed [TAP_W-1:0] refl_c;
   always_comb begin
      if (zero_ff) begin
         refl_c = '0;
      end else if (neg_ff) begin
         refl_c = q_ff[15] ? 16'sh8000 : -$signed(q_ff);
      end else begin
         refl_c = q_ff[15] ? 16'sh7fff : $signed(q_ff);
      end
   end

   // Reflectivity delay line
   always_ff @(posedge clock) begin
      if (reset || cmd.clear_trace) begin
         for (int k = 0; k < TAPS; k++) line_ff[k] <= '0;
      end else if (cmd.shift_refl || cmd.shift_zero) begin
         line_ff[0] <= cmd.shift_refl ? refl_c : '0;
         for (int k = 1; k < TAPS; k++) line_ff[k] <= line_ff[k-1];
      end
   end

   // MAC: registered product, then accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= cmd.mac_run;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mac_clear) begin
         idx_ff <= '0;
         acc_ff <= '0;
      end else begin
         if (cmd.mac_run) begin
            prod_ff <= taps_ff[idx_ff] * line_ff[idx_ff];
            idx_ff  <= idx_ff + 1'b1;
         end
         if (prod_vld_ff) begin
            acc_ff <= acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Round to 15 fractional bits and saturate to 24 bits
   logic signed [ACC_W-1:0] rnd_c;
   logic signed [SHR_W-1:0] shr_c;
   logic signed [EXT_W-1:0] ext_c;
   logic [SYNTH_W-1:0]      sat_c;

   always_comb begin
      rnd_c = acc_ff + ACC_W'(16384);
      shr_c = rnd_c[ACC_W-1:15];
      ext_c = EXT_W'(shr_c);
      if (ext_c > EXT_W'(8388607)) begin
         sat_c = 24'h7fffff;
      end else if (ext_c < -EXT_W'(8388608)) begin
         sat_c = 24'h800000;
      end else begin
         sat_c = ext_c[SYNTH_W-1:0];
      end
   end

   // Response register; next word may load as the current one leaves
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.push) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         synth_ff    <= sat_c;
         rsp_last_ff <= cmd.push_final;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = synth_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      status.req_sample = (req_tuser == CMD_SAMPLE);
      status.have_prev  = have_ff;
      status.last       = last_ff;
      status.mac_last   = (idx_ff == IDX_W'(TAPS - 1));
      status.out_free   = !rsp_valid_ff || rsp_tready;
   end

endmodule

// ===== hw/rtl/ssc_ctrl.sv =====
// Controller: sequences divide, shift, MAC, response and tail flush.
// Depends on ssc_pkg; drives ssc_datapath through dp_cmd_type.
module ssc_ctrl import ssc_pkg::*; #(
   parameter int TAPS = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   localparam int CNT_W = $clog2(TAPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_SHIFT,
      ST_MAC,
      ST_DRAIN,
      ST_PUSH,
      ST_FLUSH
   } state_type;

   state_type            state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_ff, div_in;
   logic [CNT_W-1:0]     flush_ff, flush_in;

   assign req_tready = (state_ff == ST_IDLE);

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      div_in   = div_ff;
      flush_in = flush_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (status.req_sample) begin
                  cmd.take_sample = 1'b1;
                  state_in        = ST_SETUP;
               end else begin
                  cmd.load_tap = 1'b1;
               end
            end
         end
         ST_SETUP: begin
            cmd.setup     = 1'b1;
            cmd.mac_clear = 1'b1;
            flush_in      = status.last ? CNT_W'(TAPS - 1) : '0;
            if (status.have_prev) begin
               div_in   = DIV_CNT_W'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end else begin
               // first sample of a trace: line is all zero, MAC gives zero
               state_in = ST_MAC;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_ff == '0) begin
               state_in = ST_SHIFT;
            end else begin
               div_in = div_ff - 1'b1;
            end
         end
         ST_SHIFT: begin
            cmd.shift_refl = 1'b1;
            cmd.mac_clear  = 1'b1;
            state_in       = ST_MAC;
         end
         ST_MAC: begin
            cmd.mac_run = 1'b1;
            if (status.mac_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (status.out_free) begin
               cmd.push       = 1'b1;
               cmd.push_final = status.last && (flush_ff == '0);
               if (flush_ff != '0) begin
                  flush_in = flush_ff - 1'b1;
                  state_in = ST_FLUSH;
               end else begin
                  cmd.clear_trace = status.last;
                  state_in        = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            cmd.shift_zero = 1'b1;
            cmd.mac_clear  = 1'b1;
            state_in       = ST_MAC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         div_ff   <= '0;
         flush_ff <= '0;
      end else begin
         state_ff <= state_in;
         div_ff   <= div_in;
         flush_ff <= flush_in;
      end
   end

endmodule

// ===== test/tb_synthetic_seismogram_convolver.sv =====
`timescale 1ns / 1ps
// Self-checking bench for synthetic_seismogram_convolver: wavelet loads and
// well-log traces in, synthetic trace words out, checked against a predictor.
// Depends on ssc_pkg and the convolver RTL only.
module tb_synthetic_seismogram_convolver;
   import ssc_pkg::*;

   localparam int TAPS       = 25;
   localparam int PLAN_ROWS  = 18;
   localparam int ITEM_GOAL  = 210;
   localparam int CALM_FROM  = 175;
   localparam int HOLD_LEN   = 600;
   localparam int DRAIN_WAIT = 2 * TAPS + 40;

   // One request word plus an optional hand-typed first result
   typedef struct packed {
      req_kind_type       cmd;
      logic [4:0]         idx;
      logic signed [15:0] tval;
      logic [13:0]        vel;
      logic [11:0]        den;
      logic               last;
      logic               chk;
      logic signed [23:0] exp_synth;
   } log_item_type;

   typedef struct packed {
      logic signed [23:0] synth;
      logic               last;
   } trace_word_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   synthetic_seismogram_convolver #(.TAPS(TAPS)) dut (.*);

   // Predictor state
   logic signed [15:0] wavelet [TAPS];
   logic signed [15:0] refl_line [TAPS];
   logic [25:0]        prev_imp;
   bit                 have_prev;
   trace_word_type     trace_q [$];

   log_item_type on_bus;
   int  n_errors, n_words, n_samples, n_loads, n_traces, items_sent;
   bit  calm, hold_req;

   // Directed plan: extremes, ignored loads, zero sum, saturation, flushes
   log_item_type directed_plan [PLAN_ROWS] = '{
      // first sample after reset gives zero
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd16383, 12'd4095, 1'b0, 1'b1, 24'sd0},
      // zero taps: the whole flush is zero
      '{CMD_SAMPLE, 5'd31, 16'sh7FFF, 14'd1,     12'd1,    1'b1, 1'b1, 24'sd0},
      // load with log fields and last set, which it ignores
      '{CMD_LOAD,   5'd0,  16'sh7FFF, 14'd16383, 12'd4095, 1'b1, 1'b0, 24'sd0},
      // out-of-range tap indexes
      '{CMD_LOAD,   5'd31, 16'sh8000, 14'd0,     12'd0,    1'b0, 1'b0, 24'sd0},
      '{CMD_LOAD,   5'd25, 16'sh1234, 14'd7,     12'd9,    1'b0, 1'b0, 24'sd0},
      // zero impedance start
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd0,     12'd0,    1'b0, 1'b1, 24'sd0},
      // zero impedance sum
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd0,     12'd5,    1'b0, 1'b1, 24'sd0},
      // zero previous impedance: R saturates at the top
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd16383, 12'd4095, 1'b0, 1'b1, 24'sd32766},
      // back to zero: R at the bottom
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd0,     12'd0,    1'b0, 1'b0, 24'sd0},
      // tap loads inside a trace
      '{CMD_LOAD,   5'd24, 16'sh8000, 14'd0,     12'd0,    1'b0, 1'b0, 24'sd0},
      '{CMD_LOAD,   5'd1,  16'sh4000, 14'd0,     12'd0,    1'b0, 1'b0, 24'sd0},
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd1000,  12'd2000, 1'b1, 1'b0, 24'sd0},
      // single-sample trace
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd3000,  12'd1500, 1'b1, 1'b1, 24'sd0},
      '{CMD_LOAD,   5'd2,  16'shFFFF, 14'd0,     12'd0,    1'b0, 1'b0, 24'sd0},
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd2500,  12'd2300, 1'b0, 1'b1, 24'sd0},
      // equal impedance
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd2500,  12'd2300, 1'b0, 1'b0, 24'sd0},
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd1200,  12'd1900, 1'b0, 1'b0, 24'sd0},
      '{CMD_SAMPLE, 5'd0,  16'sh0000, 14'd16383, 12'd4095, 1'b1, 1'b0, 24'sd0}
   };

   // Clock and run limit
   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      n_errors++;
      $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   // Reflection coefficient in Q1.15, rounded half away from zero
   function automatic logic signed [15:0] reflection_of(logic [25:0] z, logic [25:0] zp);
      longint unsigned sum;
      longint unsigned mag;
      longint unsigned q;
      sum = 64'(z) + 64'(zp);
      if (sum == 0) return 16'sd0;
      if (z < zp) begin
         mag = 64'(zp) - 64'(z);
         q = (mag * 32768 + sum / 2) / sum;
         if (q > 32768) q = 32768;
         return 16'(64'd0 - q);
      end
      mag = 64'(z) - 64'(zp);
      q = (mag * 32768 + sum / 2) / sum;
      if (q > 32767) q = 32767;
      return 16'(q);
   endfunction

   // Dot product of wavelet and delay line, rounded to Q15 and clipped to 24 bits
   function automatic logic signed [23:0] trace_sample();
      longint acc;
      int     i;
      acc = 0;
      for (i = 0; i < TAPS; i++) acc += longint'(wavelet[i]) * longint'(refl_line[i]);
      acc = (acc + 16384) >>> 15;
      if (acc > 8388607) acc = 8388607;
      if (acc < -8388608) acc = -8388608;
      return 24'(acc);
   endfunction

   function automatic void shift_line(logic signed [15:0] v);
      int i;
      for (i = TAPS - 1; i > 0; i--) refl_line[i] = refl_line[i-1];
      refl_line[0] = v;
   endfunction

   // Update the predictor with one accepted word and queue its outputs
   task automatic predict_trace_words(input log_item_type w);
      logic [25:0]        z;
      logic signed [23:0] first;
      int                 k;
      if (w.cmd == CMD_LOAD) begin
         n_loads++;
         if (w.idx < TAPS) wavelet[w.idx] = w.tval;
         return;
      end
      n_samples++;
      z = w.vel * w.den;
      if (!have_prev) begin
         first = 24'sd0;
      end else begin
         shift_line(reflection_of(z, prev_imp));
         first = trace_sample();
      end
      trace_q.push_back('{synth: first, last: w.last && (TAPS == 1)});
      if (w.chk && first !== w.exp_synth)
         report_mismatch($sformatf("predicted %0d, hand value %0d", first, w.exp_synth));
      prev_imp  = z;
      have_prev = 1'b1;
      if (w.last) begin
         // tail flush, then a fresh trace
         for (k = 0; k < TAPS - 1; k++) begin
            shift_line(16'sd0);
            trace_q.push_back('{synth: trace_sample(), last: k == TAPS - 2});
         end
         for (k = 0; k < TAPS; k++) refl_line[k] = 16'sd0;
         prev_imp  = '0;
         have_prev = 1'b0;
         n_traces++;
      end
   endtask

   // Both channels seen at the rising edge
   always @(posedge clock) begin
      trace_word_type want;
      log_item_type   w;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (trace_q.size() == 0) begin
               report_mismatch($sformatf("unexpected word %0d", $signed(rsp_tdata)));
            end else begin
               want = trace_q.pop_front();
               n_words++;
               if ($signed(rsp_tdata) !== want.synth)
                  report_mismatch($sformatf("word %0d: synth %0d, want %0d",
                                            n_words, $signed(rsp_tdata), want.synth));
               if (rsp_tlast !== want.last)
                  report_mismatch($sformatf("word %0d: tlast %b, want %b",
                                            n_words, rsp_tlast, want.last));
            end
         end
         if (req_tvalid && req_tready) begin
            w      = on_bus;
            w.cmd  = req_kind_type'(req_tuser);
            w.idx  = req_tdata[TIDX_LSB +: IDX_IN_W];
            w.tval = req_tdata[TVAL_LSB +: TAP_W];
            w.vel  = req_tdata[VEL_LSB +: VEL_W];
            w.den  = req_tdata[DEN_LSB +: DEN_W];
            w.last = req_tlast;
            predict_trace_words(w);
         end
      end
   end

   // Receiver: random stalls, one long hold-off on request, none late in the run
   initial begin
      int n;
      int c;
      rsp_tready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (hold_req) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            for (c = 1; c < HOLD_LEN; c++) @(negedge clock);
            hold_req = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 12);
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (n - 1) @(negedge clock);
         end else begin
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
            @(negedge clock);
            rsp_tready <= 1'b1;
            repeat (n - 1) @(negedge clock);
         end
      end
   end

   function automatic log_item_type item_of(req_kind_type cmd, logic [4:0] idx,
                                            logic [15:0] tval, logic [13:0] vel,
                                            logic [11:0] den, logic last);
      return '{cmd: cmd, idx: idx, tval: tval, vel: vel, den: den, last: last,
               chk: 1'b0, exp_synth: 24'sd0};
   endfunction

   function automatic logic [15:0] pick_tap();
      case ($urandom_range(0, 7))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [13:0] pick_velocity();
      case ($urandom_range(0, 7))
         0:       return 14'd0;
         1:       return 14'd16383;
         2:       return 14'($urandom_range(1, 40));
         default: return 14'($urandom_range(0, 16383));
      endcase
   endfunction

   function automatic logic [11:0] pick_density();
      case ($urandom_range(0, 7))
         0:       return 12'd0;
         1:       return 12'd4095;
         2:       return 12'($urandom_range(1, 40));
         default: return 12'($urandom_range(0, 4095));
      endcase
   endfunction

   // Offer one word after an optional idle burst and wait for the handshake
   task automatic send_item(input log_item_type w);
      int gap;
      gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      on_bus     = w;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, w.den, w.vel, w.tval, w.idx};
      req_tuser  <= w.cmd;
      req_tlast  <= w.last;
      do @(posedge clock); while (!req_tready);
      if (w.cmd == CMD_SAMPLE || w.idx < TAPS) items_sent++;
      if (items_sent >= CALM_FROM) calm = 1'b1;
   endtask

   // Random trace: a few tap reloads, then log samples with the last one marked
   task automatic run_trace();
      int          n_load;
      int          len;
      int          k;
      logic [13:0] v;
      logic [11:0] d;
      n_load = $urandom_range(0, 4);
      for (k = 0; k < n_load; k++)
         send_item(item_of(CMD_LOAD, 5'($urandom_range(0, 31)), pick_tap(),
                           14'($urandom), 12'($urandom), 1'($urandom)));
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 14) : $urandom_range(1, 5);
      v = pick_velocity();
      d = pick_density();
      for (k = 0; k < len; k++) begin
         // stray tap load in the middle of a trace
         if ($urandom_range(0, 9) == 0)
            send_item(item_of(CMD_LOAD, 5'($urandom_range(0, 31)), pick_tap(),
                              14'($urandom), 12'($urandom), 1'($urandom)));
         // sometimes keep the previous sample for an equal impedance
         if ($urandom_range(0, 4) != 0) begin
            v = pick_velocity();
            d = pick_density();
         end
         send_item(item_of(CMD_SAMPLE, 5'($urandom), 16'($urandom), v, d, k == len - 1));
      end
   endtask

   // Stimulus and end of run
   initial begin
      int  i;
      bit  paused;
      for (i = 0; i < TAPS; i++) begin
         wavelet[i]   = 16'sd0;
         refl_line[i] = 16'sd0;
      end
      prev_imp   = '0;
      have_prev  = 1'b0;
      n_errors   = 0;
      n_words    = 0;
      n_samples  = 0;
      n_loads    = 0;
      n_traces   = 0;
      items_sent = 0;
      calm       = 1'b0;
      hold_req   = 1'b0;
      paused     = 1'b0;
      on_bus     = '0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_LOAD;
      req_tlast  = 1'b0;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) send_item(directed_plan[i]);

      // long receiver hold-off while traces keep coming
      hold_req = 1'b1;
      while (items_sent < ITEM_GOAL) begin
         run_trace();
         if (!paused && items_sent >= 120) begin
            // sender waits for the block to drain completely
            @(negedge clock);
            req_tvalid <= 1'b0;
            while (trace_q.size() != 0) @(negedge clock);
            paused = 1'b1;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b0;

      while (trace_q.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
      $display("Run covered %0d traces: %0d log samples, %0d tap loads, %0d words checked.",
               n_traces, n_samples, n_loads, n_words);
      $display("Mismatches found: %0d", n_errors);
      if (n_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ssc_pkg.sv
hw/rtl/ssc_datapath.sv
hw/rtl/ssc_ctrl.sv
hw/rtl/synthetic_seismogram_convolver.sv
test/tb_synthetic_seismogram_convolver.sv
